FILE: rtl/njs_pkg.sv
// Shared constants, types and state codes of the job scheduler.
`timescale 1ns / 1ps
`default_nettype none
package njs_pkg;

  // table size and derived index widths
  localparam int MaxProcs = 8;
  localparam int IdxW     = $clog2(MaxProcs);
  localparam int CntW     = $clog2(MaxProcs + 1);

  // field widths
  localparam int IdW    = 8;
  localparam int ArrW   = 16;
  localparam int BurstW = 16;
  localparam int TimeW  = 20;
  localparam int OrderW = 3;
  localparam int CstW   = 8;

  // config port
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 8;
  localparam logic [CfgIdxW-1:0] CfgMode = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgCst  = 1'd1;

  // load queue between front and back
  localparam int QDepth = 2;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  // selection rules
  localparam logic ModeFcfs = 1'b0;
  localparam logic ModeSjf  = 1'b1;

  typedef struct packed {
    logic [IdW-1:0]    id;
    logic [ArrW-1:0]   arrival;
    logic [BurstW-1:0] burst;
    logic              last;
  } job_t;

  typedef struct packed {
    logic            mode;
    logic [CstW-1:0] cst;
  } cfg_t;

  typedef struct packed {
    logic [IdW-1:0]    id;
    logic [OrderW-1:0] order;
    logic [TimeW-1:0]  start;
    logic [TimeW-1:0]  finish;
    logic [TimeW-1:0]  waiting;
    logic [TimeW-1:0]  turnaround;
    logic              last;
  } result_t;

  typedef enum logic [2:0] {
    S_LOAD,
    S_SCAN,
    S_ADV,
    S_EMIT,
    S_CLOSE
  } sched_state_e;

endpackage
`default_nettype wire

FILE: rtl/njs_front.sv
// Front end: takes job transfers and buffers them in a short load queue.
`timescale 1ns / 1ps
`default_nettype none
module njs_front (
  input  wire                logic clk_i,
  input  wire                logic rst_ni,
  input  wire                logic in_valid_i,
  output logic               in_ready_o,
  input  wire njs_pkg::job_t in_job_i,
  output logic               q_valid_o,
  input  wire                logic q_pop_i,
  output njs_pkg::job_t      q_job_o
);

  njs_pkg::job_t                   mem_q [njs_pkg::QDepth];
  logic [njs_pkg::QPtrW-1:0]       wr_ptr_q, rd_ptr_q;
  logic [njs_pkg::QCntW-1:0]       cnt_q, cnt_d;
  logic                            push, pop;

  assign in_ready_o = (cnt_q != njs_pkg::QCntW'(njs_pkg::QDepth));
  assign q_valid_o  = (cnt_q != '0);
  assign q_job_o    = mem_q[rd_ptr_q];
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_pop_i && q_valid_o;

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + njs_pkg::QCntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - njs_pkg::QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_ptr_q <= wr_ptr_q + njs_pkg::QPtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + njs_pkg::QPtrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_job_i;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/njs_back.sv
// Back end: job table, slot-by-slot selection scan and result register.
`timescale 1ns / 1ps
`default_nettype none
module njs_back (
  input  wire                logic clk_i,
  input  wire                logic rst_ni,
  input  wire njs_pkg::cfg_t cfg_i,
  input  wire                logic q_valid_i,
  output logic               q_pop_o,
  input  wire njs_pkg::job_t q_job_i,
  output logic               out_valid_o,
  input  wire                logic out_ready_i,
  output njs_pkg::result_t   out_res_o
);

  // job table, written at the fill count, read at the scan index
  logic [njs_pkg::IdW-1:0]    id_mem    [njs_pkg::MaxProcs];
  logic [njs_pkg::ArrW-1:0]   arr_mem   [njs_pkg::MaxProcs];
  logic [njs_pkg::BurstW-1:0] burst_mem [njs_pkg::MaxProcs];

  njs_pkg::sched_state_e       state_q, state_d;
  logic [njs_pkg::CntW-1:0]    count_q;
  logic [njs_pkg::CntW-1:0]    slot_q;
  logic [njs_pkg::IdxW-1:0]    scan_idx_q;
  logic [njs_pkg::MaxProcs-1:0] done_q;
  logic [njs_pkg::TimeW-1:0]   cur_q;
  logic [njs_pkg::TimeW-1:0]   finish_q;

  // best candidate of the running scan
  logic                        found_q;
  logic [njs_pkg::IdxW-1:0]    best_idx_q;
  logic [njs_pkg::BurstW-1:0]  best_key_q;
  logic [njs_pkg::ArrW-1:0]    best_arr_q;
  logic [njs_pkg::BurstW-1:0]  best_burst_q;
  logic [njs_pkg::IdW-1:0]     best_id_q;
  // earliest pending arrival, for the time jump
  logic                        pend_found_q;
  logic [njs_pkg::ArrW-1:0]    earliest_q;

  logic                        out_valid_q;
  njs_pkg::result_t            out_res_q;

  // control strobes
  logic do_write, scan_clr, batch_clr, do_emit, do_close;

  // scan datapath
  logic [njs_pkg::ArrW-1:0]   ent_arr;
  logic [njs_pkg::BurstW-1:0] ent_burst;
  logic [njs_pkg::BurstW-1:0] ent_key;
  logic                       ent_done, ent_here, take, pend_take, scan_end, found_any;

  // result datapath
  logic [njs_pkg::TimeW:0]    fin_sum, turn_sum, cur_sum;
  logic [njs_pkg::TimeW-1:0]  finish, waiting, turnaround;
  logic                       out_free, last_slot;

  assign ent_arr   = arr_mem[scan_idx_q];
  assign ent_burst = burst_mem[scan_idx_q];
  assign ent_done  = done_q[scan_idx_q];
  assign ent_here  = (njs_pkg::TimeW'(ent_arr) <= cur_q);
  assign ent_key   = (cfg_i.mode == njs_pkg::ModeSjf) ? ent_burst
                                                      : njs_pkg::BurstW'(ent_arr);
  // "<=" keeps the later index on ties
  assign take      = !ent_done && ent_here && (!found_q || ent_key <= best_key_q);
  assign pend_take = !ent_done && (!pend_found_q || ent_arr < earliest_q);
  assign scan_end  = (njs_pkg::CntW'(scan_idx_q) == count_q - njs_pkg::CntW'(1));
  assign found_any = found_q || take;

  assign fin_sum    = {1'b0, cur_q} + (njs_pkg::TimeW + 1)'(best_burst_q);
  assign finish     = fin_sum[njs_pkg::TimeW] ? '1 : fin_sum[njs_pkg::TimeW-1:0];
  assign waiting    = cur_q - njs_pkg::TimeW'(best_arr_q);
  assign turn_sum   = {1'b0, waiting} + (njs_pkg::TimeW + 1)'(best_burst_q);
  assign turnaround = turn_sum[njs_pkg::TimeW] ? '1 : turn_sum[njs_pkg::TimeW-1:0];
  assign cur_sum    = {1'b0, finish_q} + (njs_pkg::TimeW + 1)'(cfg_i.cst);

  assign out_free  = !out_valid_q || out_ready_i;
  assign last_slot = (slot_q == count_q - njs_pkg::CntW'(1));

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

  always_comb begin
    state_d   = state_q;
    do_write  = 1'b0;
    scan_clr  = 1'b0;
    batch_clr = 1'b0;
    do_emit   = 1'b0;
    do_close  = 1'b0;
    q_pop_o   = 1'b0;
    unique case (state_q)
      njs_pkg::S_LOAD: begin
        if (q_valid_i) begin
          q_pop_o  = 1'b1;
          do_write = (count_q < njs_pkg::CntW'(njs_pkg::MaxProcs));
          if (q_job_i.last) begin
            scan_clr = 1'b1;
            state_d  = njs_pkg::S_SCAN;
          end
        end
      end
      njs_pkg::S_SCAN: begin
        if (scan_end) begin
          state_d = found_any ? njs_pkg::S_EMIT : njs_pkg::S_ADV;
        end
      end
      njs_pkg::S_ADV: begin
        scan_clr = 1'b1;
        state_d  = njs_pkg::S_SCAN;
      end
      njs_pkg::S_EMIT: begin
        if (out_free) begin
          do_emit = 1'b1;
          state_d = njs_pkg::S_CLOSE;
        end
      end
      njs_pkg::S_CLOSE: begin
        do_close = 1'b1;
        if (last_slot) begin
          batch_clr = 1'b1;
          state_d   = njs_pkg::S_LOAD;
        end else begin
          scan_clr = 1'b1;
          state_d  = njs_pkg::S_SCAN;
        end
      end
      default: state_d = njs_pkg::S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= njs_pkg::S_LOAD;
      count_q      <= '0;
      slot_q       <= '0;
      scan_idx_q   <= '0;
      done_q       <= '0;
      cur_q        <= '0;
      found_q      <= 1'b0;
      pend_found_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;

      if (do_write) begin
        count_q <= count_q + njs_pkg::CntW'(1);
      end

      if (scan_clr) begin
        scan_idx_q   <= '0;
        found_q      <= 1'b0;
        pend_found_q <= 1'b0;
      end else if (state_q == njs_pkg::S_SCAN) begin
        scan_idx_q <= scan_idx_q + njs_pkg::IdxW'(1);
        if (take) begin
          found_q <= 1'b1;
        end
        if (pend_take) begin
          pend_found_q <= 1'b1;
        end
      end

      // nothing has arrived: jump to the earliest pending arrival
      if (state_q == njs_pkg::S_ADV) begin
        cur_q <= njs_pkg::TimeW'(earliest_q);
      end

      if (do_emit) begin
        done_q[best_idx_q] <= 1'b1;
      end

      if (do_close) begin
        if (batch_clr) begin
          count_q <= '0;
          slot_q  <= '0;
          done_q  <= '0;
          cur_q   <= '0;
        end else begin
          slot_q <= slot_q + njs_pkg::CntW'(1);
          cur_q  <= cur_sum[njs_pkg::TimeW] ? '1 : cur_sum[njs_pkg::TimeW-1:0];
        end
      end

      if (do_emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (do_write) begin
      id_mem[count_q[njs_pkg::IdxW-1:0]]    <= q_job_i.id;
      arr_mem[count_q[njs_pkg::IdxW-1:0]]   <= q_job_i.arrival;
      burst_mem[count_q[njs_pkg::IdxW-1:0]] <= q_job_i.burst;
    end
    if (state_q == njs_pkg::S_SCAN && !scan_clr) begin
      if (take) begin
        best_idx_q   <= scan_idx_q;
        best_key_q   <= ent_key;
        best_arr_q   <= ent_arr;
        best_burst_q <= ent_burst;
        best_id_q    <= id_mem[scan_idx_q];
      end
      if (pend_take) begin
        earliest_q <= ent_arr;
      end
    end
    if (do_emit) begin
      finish_q             <= finish;
      out_res_q.id         <= best_id_q;
      out_res_q.order      <= njs_pkg::OrderW'(slot_q);
      out_res_q.start      <= cur_q;
      out_res_q.finish     <= finish;
      out_res_q.waiting    <= waiting;
      out_res_q.turnaround <= turnaround;
      out_res_q.last       <= last_slot;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/nonpreemptive_job_scheduler_core.sv
// Top level of the non-preemptive FCFS / SJF job scheduler.
`timescale 1ns / 1ps
`default_nettype none
// Non-preemptive job scheduler. Jobs stream in on the slave side, one per
// transfer, and are stored in an 8-entry table (jobs past the eighth are
// dropped). The transfer with tlast set closes the batch: the block then plans
// a schedule from time 0, picking at each slot among arrived, unscheduled jobs
// the earliest arrival (mode 0) or the shortest burst (mode 1), the later table
// entry winning ties. If nothing has arrived, time jumps to the earliest pending
// arrival. Each run is followed by context_switch_time. One result per job
// leaves on the master side in run order, tlast on the final one; all times
// saturate at 2^20-1. Jobs load through a two-entry queue; while a
// schedule is planned and emitted the queue takes up to two more transfers,
// then tready stays low until the batch is done. Planning one slot walks the
// table one entry per cycle, then emits and closes the slot; a time jump
// forces a second pass, and back-pressure on the result register holds the
// emit. Write config only while idle.
module nonpreemptive_job_scheduler_core (
  input  wire  logic        clk_i,
  input  wire  logic        rst_ni,
  // config write port: 0 = mode, 1 = context_switch_time
  input  wire  logic        cfg_we_i,
  input  wire  logic [0:0]  cfg_idx_i,
  input  wire  logic [7:0]  cfg_data_i,
  // job input
  input  wire  logic        s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire  logic [39:0] s_axis_tdata,  // process_id, arrival_time, burst_time
  input  wire  logic        s_axis_tlast,  // last_process
  // schedule output
  output logic              m_axis_tvalid,
  input  wire  logic        m_axis_tready,
  // process_id_res, order_position, start_time, finish_time, waiting_time,
  // turnaround_time, 5 zero pad bits
  output logic [95:0]       m_axis_tdata,
  output logic              m_axis_tlast   // last_result
);

  njs_pkg::cfg_t    cfg_q;
  njs_pkg::job_t    in_job, q_job;
  njs_pkg::result_t res;
  logic             q_valid, q_pop;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        njs_pkg::CfgMode: cfg_q.mode <= cfg_data_i[0];
        njs_pkg::CfgCst:  cfg_q.cst  <= cfg_data_i[njs_pkg::CstW-1:0];
        default: ;
      endcase
    end
  end

  assign in_job.id      = s_axis_tdata[7:0];
  assign in_job.arrival = s_axis_tdata[23:8];
  assign in_job.burst   = s_axis_tdata[39:24];
  assign in_job.last    = s_axis_tlast;

  njs_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_job_i   (in_job),
    .q_valid_o  (q_valid),
    .q_pop_i    (q_pop),
    .q_job_o    (q_job)
  );

  njs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .q_job_i     (q_job),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (res)
  );

  assign m_axis_tdata = {5'b0, res.turnaround, res.waiting, res.finish, res.start,
                         res.order, res.id};
  assign m_axis_tlast = res.last;

endmodule
`default_nettype wire
